@@ rtl/llrs_pkg.sv @@
// Shared types and constants for the link-loss reset supervisor.
// No dependencies; link_loss_reset_supervisor.sv imports this package.
package llrs_pkg;

    // Timer counter width; counters saturate at all ones
    localparam int TIMER_BITS = 32;
    // Comparison width: wide enough for both a counter and a 32-bit register
    localparam int CMP_BITS = (TIMER_BITS > 32) ? TIMER_BITS : 32;

    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFLINE_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSE_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ATTEMPTS = 2'd2;

    // Configuration reset values
    localparam logic [31:0] OFFLINE_INTERVAL_RESET = 32'd1800000;
    localparam logic [31:0] PULSE_LENGTH_RESET = 32'd10000;
    localparam logic [7:0] MAX_ATTEMPTS_RESET = 8'd15;

    // Request command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_RELAY_LOW = 2'd1;
    localparam logic [1:0] CMD_RELAY_HIGH = 2'd2;

    typedef logic [TIMER_BITS-1:0] timer_t;

    // Result payload
    typedef struct packed {
        logic       relay_level;
        logic       pulse_active;
        logic       offline_tracking;
        logic [7:0] attempt_count;
        logic       limit_reached;
    } result_t;

endpackage

@@ rtl/llrs_if.sv @@
// Valid/ready channel interfaces for the link-loss reset supervisor.
// Depends on nothing; request and result channels each have their own interface.
interface llrs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       link_up;

    modport source (output valid, output cmd, output link_up, input ready);
    modport sink (input valid, input cmd, input link_up, output ready);
endinterface

interface llrs_res_if;
    logic       valid;
    logic       ready;
    logic       relay_level;
    logic       pulse_active;
    logic       offline_tracking;
    logic [7:0] attempt_count;
    logic       limit_reached;

    modport source (output valid, output relay_level, output pulse_active,
                    output offline_tracking, output attempt_count,
                    output limit_reached, input ready);
    modport sink (input valid, input relay_level, input pulse_active,
                  input offline_tracking, input attempt_count,
                  input limit_reached, output ready);
endinterface

@@ rtl/link_loss_reset_supervisor.sv @@
// Link-loss reset supervisor top level: state registers, update logic, result register.
// Depends on llrs_pkg and the channel interfaces in llrs_if.sv.
//
// Every request (a one-millisecond tick carrying the link-up flag, or a manual
// relay command) is accepted whole and yields exactly one result,
// which appears in the result register on the next cycle. The block takes a
// new request every cycle as long as the result register is empty or its
// result is being taken in the same cycle; the one result register is the
// only buffering, so sustained throughput is one request per clock. Offline
// interval and pulse timers are saturating up-counters; configuration writes
// take effect on the next request.
module link_loss_reset_supervisor (
    input  logic                                 clk,
    input  logic                                 rst_n,
    llrs_req_if.sink                             req_ch,
    llrs_res_if.source                           res_ch,
    input  logic                                 cfg_we,
    input  logic [llrs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [llrs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import llrs_pkg::*;

    // Configuration registers
    logic [31:0] offline_interval_reg;
    logic [31:0] pulse_length_reg;
    logic [7:0]  max_attempts_reg;

    // Supervisor state
    logic       prev_link_reg, prev_link_next;
    logic       tracking_flag_reg, tracking_flag_next;
    logic       pulse_flag_reg, pulse_flag_next;
    logic       limit_flag_reg, limit_flag_next;
    logic [7:0] attempts_reg, attempts_next;
    timer_t     interval_elapsed_reg, interval_elapsed_next;
    timer_t     pulse_elapsed_reg, pulse_elapsed_next;
    logic       relay_reg, relay_next;

    // Result register
    logic    res_valid_reg;
    result_t res_data_reg;

    logic   req_acc;
    timer_t interval_inc;
    timer_t pulse_inc;
    logic   pulse_done;
    logic   interval_done;

    // Accept while the result register is free or draining
    assign req_ch.ready = !res_valid_reg || res_ch.ready;
    assign req_acc = req_ch.valid && req_ch.ready;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offline_interval_reg <= OFFLINE_INTERVAL_RESET;
            pulse_length_reg <= PULSE_LENGTH_RESET;
            max_attempts_reg <= MAX_ATTEMPTS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OFFLINE_INTERVAL: offline_interval_reg <= cfg_data[31:0];
                CFG_PULSE_LENGTH:     pulse_length_reg <= cfg_data[31:0];
                CFG_MAX_ATTEMPTS:     max_attempts_reg <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    // Saturating increments and threshold compares
    assign interval_inc = (&interval_elapsed_reg) ? interval_elapsed_reg
                                                  : interval_elapsed_reg + 1'b1;
    assign pulse_inc = (&pulse_elapsed_reg) ? pulse_elapsed_reg
                                            : pulse_elapsed_reg + 1'b1;
    assign pulse_done = CMP_BITS'(pulse_inc) >= CMP_BITS'(pulse_length_reg);
    assign interval_done = CMP_BITS'(interval_inc) >= CMP_BITS'(offline_interval_reg);

    // Compute the state after one request
    always_comb
    begin
        prev_link_next = prev_link_reg;
        tracking_flag_next = tracking_flag_reg;
        pulse_flag_next = pulse_flag_reg;
        limit_flag_next = limit_flag_reg;
        attempts_next = attempts_reg;
        interval_elapsed_next = interval_elapsed_reg;
        pulse_elapsed_next = pulse_elapsed_reg;
        relay_next = relay_reg;
        case (req_ch.cmd)
            CMD_TICK:
            begin
                prev_link_next = req_ch.link_up;
                if (req_ch.link_up)
                begin
                    // Link up: drop all recovery state and release the relay
                    if (!prev_link_reg || tracking_flag_reg || pulse_flag_reg
                        || (attempts_reg != 8'd0))
                    begin
                        relay_next = 1'b1;
                        tracking_flag_next = 1'b0;
                        pulse_flag_next = 1'b0;
                        limit_flag_next = 1'b0;
                        attempts_next = 8'd0;
                        interval_elapsed_next = '0;
                        pulse_elapsed_next = '0;
                    end
                end
                else if (!tracking_flag_reg)
                begin
                    // First offline tick: start timing
                    relay_next = 1'b1;
                    tracking_flag_next = 1'b1;
                    interval_elapsed_next = '0;
                end
                else
                begin
                    interval_elapsed_next = interval_inc;
                    pulse_elapsed_next = pulse_inc;
                    if (pulse_flag_reg)
                    begin
                        // End the pulse once its length has run
                        if (pulse_done)
                        begin
                            relay_next = 1'b1;
                            pulse_flag_next = 1'b0;
                        end
                    end
                    else if (attempts_reg >= max_attempts_reg)
                    begin
                        limit_flag_next = 1'b1;
                    end
                    else if (interval_done)
                    begin
                        // Start a reset pulse
                        relay_next = 1'b0;
                        pulse_flag_next = 1'b1;
                        pulse_elapsed_next = '0;
                        interval_elapsed_next = '0;
                        attempts_next = attempts_reg + 8'd1;
                    end
                end
            end
            CMD_RELAY_LOW:  relay_next = 1'b0;
            CMD_RELAY_HIGH: relay_next = 1'b1;
            default:        ;
        endcase
    end

    // Advance state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_link_reg <= 1'b0;
            tracking_flag_reg <= 1'b0;
            pulse_flag_reg <= 1'b0;
            limit_flag_reg <= 1'b0;
            attempts_reg <= 8'd0;
            interval_elapsed_reg <= '0;
            pulse_elapsed_reg <= '0;
            relay_reg <= 1'b1;
        end
        else if (req_acc)
        begin
            prev_link_reg <= prev_link_next;
            tracking_flag_reg <= tracking_flag_next;
            pulse_flag_reg <= pulse_flag_next;
            limit_flag_reg <= limit_flag_next;
            attempts_reg <= attempts_next;
            interval_elapsed_reg <= interval_elapsed_next;
            pulse_elapsed_reg <= pulse_elapsed_next;
            relay_reg <= relay_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (req_acc)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            res_data_reg.relay_level <= relay_next;
            res_data_reg.pulse_active <= pulse_flag_next;
            res_data_reg.offline_tracking <= tracking_flag_next;
            res_data_reg.attempt_count <= attempts_next;
            res_data_reg.limit_reached <= limit_flag_next;
        end
    end

    assign res_ch.valid = res_valid_reg;
    assign res_ch.relay_level = res_data_reg.relay_level;
    assign res_ch.pulse_active = res_data_reg.pulse_active;
    assign res_ch.offline_tracking = res_data_reg.offline_tracking;
    assign res_ch.attempt_count = res_data_reg.attempt_count;
    assign res_ch.limit_reached = res_data_reg.limit_reached;

    // A pulse is only ever held while offline timing runs
    a_pulse_needs_tracking: assert property (
        @(posedge clk) disable iff (!rst_n)
        pulse_flag_reg |-> tracking_flag_reg
    ) else $error("pulse active without offline tracking");

    // A new pulse counts one attempt and pulls the relay low
    a_pulse_start: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(pulse_flag_reg) |->
            (attempts_reg == $past(attempts_reg) + 8'd1) && !relay_reg
    ) else $error("pulse started without attempt count or relay low");

    // Both timers restart when a pulse begins
    a_pulse_start_timers: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(pulse_flag_reg) |->
            (interval_elapsed_reg == '0) && (pulse_elapsed_reg == '0)
    ) else $error("timers not cleared at pulse start");

    // Attempt count, tracking flag and relay move only with an accepted request
    a_state_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        !req_acc |=> $stable(attempts_reg) && $stable(tracking_flag_reg)
            && $stable(relay_reg)
    ) else $error("state changed without a request");

endmodule
